FILE: hdl/chtfl_pkg.sv
// ----------------------------------------------------------------------------
// chtfl_pkg
// Shared types and codes for the chained hash table with free-list pool.
// ----------------------------------------------------------------------------
package chtfl_pkg;

  // Default store size (home buckets plus overflow pool)
  localparam int TABLE_SIZE_DEF = 16;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Result status codes
  localparam logic [2:0] RS_HOME_INS  = 3'd0;
  localparam logic [2:0] RS_CHAIN_INS = 3'd1;
  localparam logic [2:0] RS_FULL      = 3'd2;
  localparam logic [2:0] RS_HOME_DEL  = 3'd3;
  localparam logic [2:0] RS_CHAIN_DEL = 3'd4;
  localparam logic [2:0] RS_NOT_FOUND = 3'd5;

  // Home bucket status codes
  localparam logic [1:0] HS_EMPTY    = 2'd0;
  localparam logic [1:0] HS_OCCUPIED = 2'd1;
  localparam logic [1:0] HS_DELETED  = 2'd2;

  // Input item
  typedef struct packed {
    logic       opcode;
    logic [7:0] key;
  } chtfl_in_t;

  // Result item
  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
  } chtfl_out_t;

  // Store access strobes from the sequencer
  typedef struct packed {
    logic rd;
    logic key_we;
    logic link_we;
    logic stat_we;
  } chtfl_mem_ctl_t;

endpackage

FILE: hdl/chtfl_store.sv
// ----------------------------------------------------------------------------
// chtfl_store
// Key, link and home-status memories with one shared read port (registered)
// and one shared write address. Links and status carry per-entry valid bits
// so that unwritten entries read as their reset values.
// ----------------------------------------------------------------------------
module chtfl_store #(
  parameter int TABLE_SIZE = chtfl_pkg::TABLE_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  chtfl_pkg::chtfl_mem_ctl_t        ctl,
  input  logic [$clog2(TABLE_SIZE)-1:0]    rd_addr,
  input  logic [$clog2(TABLE_SIZE)-1:0]    wr_addr,
  input  logic [7:0]                       key_wdata,
  input  logic [$clog2(TABLE_SIZE+1)-1:0]  link_wdata,
  input  logic [1:0]                       stat_wdata,
  output logic [7:0]                       key_rd,
  output logic [$clog2(TABLE_SIZE+1)-1:0]  link_rd,
  output logic [1:0]                       stat_rd
);
  import chtfl_pkg::*;

  localparam int HALF  = TABLE_SIZE / 2;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int LW    = $clog2(TABLE_SIZE + 1);
  localparam int HW    = $clog2(HALF);

  logic [7:0]      key_mem  [TABLE_SIZE];
  logic [LW-1:0]   link_mem [TABLE_SIZE];
  logic [1:0]      stat_mem [HALF];

  logic [TABLE_SIZE-1:0] link_vld_r;
  logic [HALF-1:0]       stat_vld_r;

  logic [7:0]       key_q_r;
  logic [LW-1:0]    link_q_r;
  logic [1:0]       stat_q_r;
  logic             link_vq_r;
  logic             stat_vq_r;
  logic [IDX_W-1:0] raddr_q_r;
  logic [LW-1:0]    link_rst;

  // Status is only read at a home index, which fits the low bits
  logic [HW-1:0] stat_ra;
  logic [HW-1:0] stat_wa;
  assign stat_ra = rd_addr[HW-1:0];
  assign stat_wa = wr_addr[HW-1:0];

  // Memory writes
  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[wr_addr] <= key_wdata;
    end
    if (ctl.link_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
    if (ctl.stat_we) begin
      stat_mem[stat_wa] <= stat_wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      key_q_r   <= key_mem[rd_addr];
      link_q_r  <= link_mem[rd_addr];
      stat_q_r  <= stat_mem[stat_ra];
      link_vq_r <= link_vld_r[rd_addr];
      stat_vq_r <= stat_vld_r[stat_ra];
      raddr_q_r <= rd_addr;
    end
  end

  // Valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
      stat_vld_r <= '0;
    end else begin
      if (ctl.link_we) begin
        link_vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.stat_we) begin
        stat_vld_r[stat_wa] <= 1'b1;
      end
    end
  end

  // Reset link value: home and last pool entry are null, pool chains upward
  always_comb begin
    if (raddr_q_r < IDX_W'(HALF) || raddr_q_r == IDX_W'(TABLE_SIZE - 1)) begin
      link_rst = LW'(TABLE_SIZE);
    end else begin
      link_rst = LW'(raddr_q_r) + LW'(1);
    end
  end

  assign key_rd  = key_q_r;
  assign link_rd = link_vq_r ? link_q_r : link_rst;
  assign stat_rd = stat_vq_r ? stat_q_r : HS_EMPTY;

endmodule

FILE: hdl/chtfl_seq.sv
// ----------------------------------------------------------------------------
// chtfl_seq
// Operation sequencer: hashes the key, decides home or chain handling,
// walks chains one node per cycle and maintains the free-list head.
// ----------------------------------------------------------------------------
module chtfl_seq #(
  parameter int TABLE_SIZE = chtfl_pkg::TABLE_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  chtfl_pkg::chtfl_in_t             in_item,
  output logic                             out_strobe,
  output chtfl_pkg::chtfl_out_t            out_item,
  output chtfl_pkg::chtfl_mem_ctl_t        ctl,
  output logic [$clog2(TABLE_SIZE)-1:0]    rd_addr,
  output logic [$clog2(TABLE_SIZE)-1:0]    wr_addr,
  output logic [7:0]                       key_wdata,
  output logic [$clog2(TABLE_SIZE+1)-1:0]  link_wdata,
  output logic [1:0]                       stat_wdata,
  input  logic [7:0]                       key_rd,
  input  logic [$clog2(TABLE_SIZE+1)-1:0]  link_rd,
  input  logic [1:0]                       stat_rd
);
  import chtfl_pkg::*;

  localparam int HALF  = TABLE_SIZE / 2;
  localparam int POOL  = TABLE_SIZE - HALF;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int LW    = $clog2(TABLE_SIZE + 1);
  localparam int HW    = $clog2(HALF);
  localparam int SW    = $clog2(POOL + 1);

  localparam logic [LW-1:0] NULL_LINK = LW'(TABLE_SIZE);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HOME = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_LINK = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_FREE = 3'd5;

  // Key to home bucket table, built without a divider
  function automatic logic [256*HW-1:0] home_lut_f();
    logic [256*HW-1:0] t;
    int m;
    t = '0;
    m = 0;
    for (int i = 0; i < 256; i++) begin
      t[i*HW +: HW] = HW'(m);
      m = m + 1;
      if (m == HALF) begin
        m = 0;
      end
    end
    return t;
  endfunction

  localparam logic [256*HW-1:0] HOME_LUT = home_lut_f();

  logic [2:0]       state_r, state_nxt;
  logic             op_r, op_nxt;
  logic [7:0]       key_r, key_nxt;
  logic [HW-1:0]    home_r, home_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic [SW-1:0]    steps_r, steps_nxt;
  logic [LW-1:0]    hlink_r, hlink_nxt;
  logic [LW-1:0]    free_head_r, free_head_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  chtfl_out_t       out_item_r, out_item_nxt;

  logic [HW-1:0]      home_in;
  logic [IDX_W-1:0]   home_idx;
  logic [SW-1:0]      steps_inc;
  logic               emit;
  logic [2:0]         emit_status;
  logic [IDX_W-1:0]   emit_slot;
  logic [IDX_W+3:0]   slot_ext;

  assign home_in   = HOME_LUT[in_item.key*HW +: HW];
  assign home_idx  = IDX_W'(home_r);
  assign steps_inc = steps_r + SW'(1);
  assign slot_ext  = {4'b0000, emit_slot};

  // Next-state and store control
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    home_nxt      = home_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    hlink_nxt     = hlink_r;
    free_head_nxt = free_head_r;
    ctl           = '0;
    rd_addr       = '0;
    wr_addr       = '0;
    key_wdata     = key_r;
    link_wdata    = '0;
    stat_wdata    = HS_OCCUPIED;
    emit          = 1'b0;
    emit_status   = RS_NOT_FOUND;
    emit_slot     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_item.opcode;
          key_nxt   = in_item.key;
          home_nxt  = home_in;
          ctl.rd    = 1'b1;
          rd_addr   = IDX_W'(home_in);
          state_nxt = S_HOME;
        end
      end

      S_HOME: begin
        if (op_r == OP_INSERT) begin
          if (stat_rd != HS_OCCUPIED) begin
            // Home bucket free: store there
            ctl.key_we  = 1'b1;
            ctl.stat_we = 1'b1;
            wr_addr     = home_idx;
            stat_wdata  = HS_OCCUPIED;
            emit        = 1'b1;
            emit_status = RS_HOME_INS;
            emit_slot   = home_idx;
          end else if (free_head_r == NULL_LINK) begin
            emit        = 1'b1;
            emit_status = RS_FULL;
          end else begin
            // Fetch the link of the free-list head
            ctl.rd    = 1'b1;
            rd_addr   = free_head_r[IDX_W-1:0];
            cur_nxt   = free_head_r[IDX_W-1:0];
            hlink_nxt = link_rd;
            state_nxt = S_POP;
          end
        end else begin
          if (stat_rd == HS_OCCUPIED && key_rd == key_r) begin
            ctl.stat_we = 1'b1;
            wr_addr     = home_idx;
            stat_wdata  = HS_DELETED;
            emit        = 1'b1;
            emit_status = RS_HOME_DEL;
            emit_slot   = home_idx;
          end else begin
            // Start the chain walk
            prev_nxt  = home_idx;
            steps_nxt = '0;
            if (link_rd < NULL_LINK) begin
              ctl.rd    = 1'b1;
              rd_addr   = link_rd[IDX_W-1:0];
              cur_nxt   = link_rd[IDX_W-1:0];
              state_nxt = S_WALK;
            end else begin
              emit        = 1'b1;
              emit_status = RS_NOT_FOUND;
            end
          end
        end
      end

      S_POP: begin
        // Pop node, fill it and point it at the old home successor
        free_head_nxt = link_rd;
        ctl.key_we    = 1'b1;
        ctl.link_we   = 1'b1;
        wr_addr       = cur_r;
        link_wdata    = hlink_r;
        state_nxt     = S_LINK;
      end

      S_LINK: begin
        ctl.link_we = 1'b1;
        wr_addr     = home_idx;
        link_wdata  = LW'(cur_r);
        emit        = 1'b1;
        emit_status = RS_CHAIN_INS;
        emit_slot   = cur_r;
      end

      S_WALK: begin
        if (key_rd == key_r) begin
          // Unlink: predecessor skips the matching node
          ctl.link_we = 1'b1;
          wr_addr     = prev_r;
          link_wdata  = link_rd;
          state_nxt   = S_FREE;
        end else begin
          prev_nxt  = cur_r;
          steps_nxt = steps_inc;
          if (steps_inc < SW'(POOL) && link_rd < NULL_LINK) begin
            ctl.rd  = 1'b1;
            rd_addr = link_rd[IDX_W-1:0];
            cur_nxt = link_rd[IDX_W-1:0];
          end else begin
            emit        = 1'b1;
            emit_status = RS_NOT_FOUND;
          end
        end
      end

      S_FREE: begin
        // Push freed node onto the free list
        ctl.link_we   = 1'b1;
        wr_addr       = cur_r;
        link_wdata    = free_head_r;
        free_head_nxt = LW'(cur_r);
        emit          = 1'b1;
        emit_status   = RS_CHAIN_DEL;
        emit_slot     = cur_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      state_nxt = S_IDLE;
    end
    out_strobe_nxt      = emit;
    out_item_nxt.status = emit_status;
    out_item_nxt.slot   = slot_ext[3:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= LW'(HALF);
      out_strobe_r <= 1'b0;
      steps_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      out_strobe_r <= out_strobe_nxt;
      steps_r      <= steps_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    home_r     <= home_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    hlink_r    <= hlink_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  // A result only follows a cycle of work
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r != S_IDLE))
    else $error("result strobe without preceding operation");

  // Free-list head is null or a pool index
  a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r == NULL_LINK ||
    (free_head_r >= LW'(HALF) && free_head_r < NULL_LINK))
    else $error("free-list head outside the pool");

  // An accepted command goes to the home lookup
  a_start_to_home: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == S_HOME)
    else $error("accepted command did not start lookup");

  // The walk never goes past the pool size
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> steps_r < SW'(POOL))
    else $error("chain walk exceeded pool size");
`endif

endmodule

FILE: hdl/chained_hash_table_free_list_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_free_list_unit
// Hash table of 8-bit keys: home buckets plus a free-listed overflow pool.
// ----------------------------------------------------------------------------
// A command (insert or delete a key) is taken when start is high and busy is
// low; exactly one result follows, shown for a single cycle with out_strobe,
// and the receiver must take it then. A home insert, full drop or home delete
// ends with the home lookup; a chain insert adds a free-list pop and two
// link writes; a chain delete and a miss add a walk of the chain nodes,
// at most TABLE_SIZE/2 of them, and a chain delete then frees the node. The
// chain walk is set by the single registered read port of the store, one
// node per cycle. busy drops in the cycle the result is shown, so a new
// command may be taken then.
module chained_hash_table_free_list_unit #(
  parameter int TABLE_SIZE = chtfl_pkg::TABLE_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  chtfl_pkg::chtfl_in_t  in_item,
  output logic                  out_strobe,
  output chtfl_pkg::chtfl_out_t out_item
);
  import chtfl_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int LW    = $clog2(TABLE_SIZE + 1);

  chtfl_mem_ctl_t   ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       key_wdata;
  logic [LW-1:0]    link_wdata;
  logic [1:0]       stat_wdata;
  logic [7:0]       key_rd;
  logic [LW-1:0]    link_rd;
  logic [1:0]       stat_rd;

  // Sequencer
  chtfl_seq #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .key_wdata  (key_wdata),
    .link_wdata (link_wdata),
    .stat_wdata (stat_wdata),
    .key_rd     (key_rd),
    .link_rd    (link_rd),
    .stat_rd    (stat_rd)
  );

  // Table storage
  chtfl_store #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .key_wdata  (key_wdata),
    .link_wdata (link_wdata),
    .stat_wdata (stat_wdata),
    .key_rd     (key_rd),
    .link_rd    (link_rd),
    .stat_rd    (stat_rd)
  );

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chained hash table with free-list pool.
// Drives insert and delete commands through the start/busy handshake,
// keeps a shadow of the buckets, links and free list to predict every result,
// and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import chtfl_pkg::*;

  localparam int SLOTS        = TABLE_SIZE_DEF;
  localparam int HOMES        = SLOTS / 2;
  localparam int RANDOM_CMDS  = 850;
  localparam int QUIET_TAIL   = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_TIME   = 2_000_000;

  // Shadow of the table contents; predicts one result per command
  class hash_table_shadow;
    logic [7:0] key_mem [SLOTS];
    logic [4:0] link_mem [SLOTS];
    logic [1:0] bucket_state [HOMES];
    logic [4:0] free_head;
    chtfl_out_t pending_results [$];
    int         err_count;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        key_mem[i]  = '0;
        link_mem[i] = (i < HOMES || i == SLOTS - 1) ? 5'(SLOTS) : 5'(i + 1);
      end
      for (int i = 0; i < HOMES; i++) bucket_state[i] = HS_EMPTY;
      free_head = 5'(HOMES);
      err_count = 0;
    endfunction

    function void report(string what, int want, int got);
      err_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Accepted command: update the shadow and queue the predicted result
    function void apply_command(chtfl_in_t cmd);
      int         home;
      int         node;
      int         prev;
      int         cur;
      int         steps;
      chtfl_out_t res;
      home = int'(cmd.key) % HOMES;
      res  = '0;
      if (cmd.opcode == OP_INSERT) begin
        if (bucket_state[home] != HS_OCCUPIED) begin
          key_mem[home]      = cmd.key;
          bucket_state[home] = HS_OCCUPIED;
          res.status         = RS_HOME_INS;
          res.slot           = 4'(home);
        end else if (free_head >= SLOTS) begin
          res.status = RS_FULL;
        end else begin
          // pop the free list, link the node right after the home bucket
          node           = free_head;
          free_head      = link_mem[node];
          key_mem[node]  = cmd.key;
          link_mem[node] = link_mem[home];
          link_mem[home] = 5'(node);
          res.status     = RS_CHAIN_INS;
          res.slot       = 4'(node);
        end
      end else if (bucket_state[home] == HS_OCCUPIED && key_mem[home] == cmd.key) begin
        bucket_state[home] = HS_DELETED;
        res.status         = RS_HOME_DEL;
        res.slot           = 4'(home);
      end else begin
        // walk the chain; first match goes back to the free list head
        res.status = RS_NOT_FOUND;
        prev  = home;
        cur   = link_mem[home];
        steps = 0;
        while (cur < SLOTS && steps < SLOTS - HOMES) begin
          if (key_mem[cur] == cmd.key) begin
            link_mem[prev] = link_mem[cur];
            link_mem[cur]  = free_head;
            free_head      = 5'(cur);
            res.status     = RS_CHAIN_DEL;
            res.slot       = 4'(cur);
            break;
          end
          prev = cur;
          cur  = link_mem[cur];
          steps++;
        end
      end
      pending_results.push_back(res);
    endfunction

    // Strobed result: compare with the oldest prediction
    function void check_result(chtfl_out_t got);
      chtfl_out_t want;
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: expected none, actual status %0d slot %0d",
                 $time, got.status, got.slot);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.slot !== want.slot) report("slot", want.slot, got.slot);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  chtfl_in_t  in_item;
  logic       out_strobe;
  chtfl_out_t out_item;

  hash_table_shadow shadow;

  chained_hash_table_free_list_unit #(
    .TABLE_SIZE(SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: results and command transfers, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) shadow.check_result(out_item);
      if (start && !busy) shadow.apply_command(in_item);
    end
  end

  // One command; returns at the edge that transfers it
  task automatic send_cmd(logic op, logic [7:0] k);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= '{opcode: op, key: k};
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Sender gap with junk on the command bus
  task automatic idle_gap(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= chtfl_in_t'(9'($urandom));
    end
  endtask

  // Hold off until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [7:0] live_keys [$];
    logic [7:0] k;
    logic [2:0] home_base;
    int         ins_pct;
    int         spread;
    int         pick;
    bit         gaps_on;

    shadow  = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: home, chain and duplicate inserts, both delete kinds, misses
    send_cmd(OP_INSERT, 8'd0);
    send_cmd(OP_INSERT, 8'd8);
    send_cmd(OP_INSERT, 8'd0);
    send_cmd(OP_INSERT, 8'd255);
    send_cmd(OP_DELETE, 8'd8);
    send_cmd(OP_DELETE, 8'd0);
    send_cmd(OP_DELETE, 8'd0);
    send_cmd(OP_DELETE, 8'd0);
    // miss on an empty home bucket
    send_cmd(OP_DELETE, 8'd3);
    // deleted home bucket is reused while its chain stays
    send_cmd(OP_INSERT, 8'd128);
    // fill the whole pool behind one bucket, then one more is dropped
    for (int i = 0; i < 9; i++) send_cmd(OP_INSERT, 8'(7 + 8 * i));
    send_cmd(OP_DELETE, 8'd39);
    send_cmd(OP_DELETE, 8'd7);
    send_cmd(OP_DELETE, 8'd255);
    send_cmd(OP_INSERT, 8'd71);
    send_cmd(OP_DELETE, 8'd71);
    wait_drained();

    // Random: colliding keys, mostly deletes of live keys, some noise
    ins_pct   = 50;
    spread    = 7;
    home_base = '0;
    gaps_on   = 1'b1;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 50 == 0) begin
        ins_pct   = $urandom_range(30, 80);
        spread    = $urandom_range(0, 7);
        home_base = 3'($urandom);
        gaps_on   = ($urandom_range(0, 2) != 0);
      end
      if (n == RANDOM_CMDS / 2) wait_drained();
      if (gaps_on && n < RANDOM_CMDS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        idle_gap($urandom_range(1, 8));
      if ($urandom_range(0, 99) < ins_pct || live_keys.size() == 0) begin
        if ($urandom_range(0, 19) == 0) k = 8'($urandom);
        else k = {5'($urandom), 3'(home_base + 3'($urandom_range(0, spread)))};
        send_cmd(OP_INSERT, k);
        live_keys.push_back(k);
        if (live_keys.size() > 40) void'(live_keys.pop_front());
      end else if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, live_keys.size() - 1);
        k    = live_keys[pick];
        live_keys.delete(pick);
        send_cmd(OP_DELETE, k);
      end else begin
        send_cmd(OP_DELETE, 8'($urandom));
      end
    end

    // Drain and settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.err_count == 0) begin
      $display("[chained_hash_table_free_list_unit] OK");
    end else begin
      $display("[chained_hash_table_free_list_unit] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #LIMIT_TIME;
    $display("[chained_hash_table_free_list_unit] ERROR");
    $finish;
  end

endmodule

FILE: files.f
hdl/chtfl_pkg.sv
hdl/chtfl_store.sv
hdl/chtfl_seq.sv
hdl/chained_hash_table_free_list_unit.sv
bench/tb_top.sv
